// ===== hw/rtl/clr_pkg.sv =====
`timescale 1ns / 1ps

package clr_pkg;

  // panel geometry and coordinate width
  localparam int unsigned PANEL_WIDTH  = 240;
  localparam int unsigned PANEL_HEIGHT = 320;
  localparam int unsigned COORD_BITS   = 11;
  localparam int unsigned COLOR_BITS   = 16;
  localparam int unsigned ADDR_BITS    = 17;
  localparam int unsigned ERR_BITS     = COORD_BITS + 2;
  localparam int unsigned PANEL_PIXELS = PANEL_WIDTH * PANEL_HEIGHT;

  // pixel queue between walker and address mapper
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // input item kinds
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ORIENT_PORTRAIT     = 2'd0,
    ORIENT_INV_PORTRAIT = 2'd1,
    ORIENT_LEFT_LAND    = 2'd2,
    ORIENT_RIGHT_LAND   = 2'd3
  } orient_e;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  fb_address;
    logic [COLOR_BITS-1:0] out_color;
    logic                  write_enable;
    logic                  last_pixel;
  } out_item_t;

  // one walked pixel in logical coordinates
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pix_t;

endpackage

// ===== hw/rtl/clr_front.sv =====
`timescale 1ns / 1ps

module clr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  clr_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output clr_pkg::pix_t     push_data_o
);
  import clr_pkg::*;

  logic                       active_q, active_d;
  logic [COORD_BITS-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]      goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic [COORD_BITS-1:0]      dx_q, dx_d, dy_q, dy_d;
  logic                       neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [ERR_BITS-1:0] err_q, err_d;
  logic [COLOR_BITS-1:0]      color_q, color_d;

  logic                       accept;
  logic                       last;
  logic signed [ERR_BITS:0]   e2;
  logic signed [ERR_BITS:0]   dx_s, dy_s, err_sum;
  logic                       step_x, step_y;
  logic [COORD_BITS-1:0]      x1, y1, x2, y2;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  assign x1 = in_data_i.start_x;
  assign y1 = in_data_i.start_y;
  assign x2 = in_data_i.end_x;
  assign y2 = in_data_i.end_y;

  // bresenham step decision
  assign last   = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
  assign e2     = {err_q[ERR_BITS-1], err_q} <<< 1;
  assign dx_s   = $signed({2'b00, dx_q});
  assign dy_s   = $signed({2'b00, dy_q});
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;
  assign err_sum = {err_q[ERR_BITS-1], err_q}
                 - (step_x ? dy_s : '0)
                 + (step_y ? dx_s : '0);

  // pixel handed to the queue
  assign push_o            = accept && (in_data_i.kind == KIND_TICK) && active_q;
  assign push_data_o.x     = cur_x_q;
  assign push_data_o.y     = cur_y_q;
  assign push_data_o.color = color_q;
  assign push_data_o.last  = last;

  // line load and walk
  always_comb begin
    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    err_d    = err_q;
    color_d  = color_q;
    if (accept && (in_data_i.kind == KIND_LINE)) begin
      cur_x_d  = x1;
      cur_y_d  = y1;
      goal_x_d = x2;
      goal_y_d = y2;
      dx_d     = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy_d     = (y2 > y1) ? y2 - y1 : y1 - y2;
      neg_x_d  = !(x1 < x2);
      neg_y_d  = !(y1 < y2);
      err_d    = $signed({2'b00, dx_d}) - $signed({2'b00, dy_d});
      color_d  = in_data_i.pixel_color;
      active_d = 1'b1;
    end else if (push_o) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        err_d = err_sum[ERR_BITS-1:0];
        if (step_x) begin
          cur_x_d = neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        end
        if (step_y) begin
          cur_y_d = neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    goal_x_q <= goal_x_d;
    goal_y_q <= goal_y_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    neg_x_q  <= neg_x_d;
    neg_y_q  <= neg_y_d;
    err_q    <= err_d;
    color_q  <= color_d;
  end

endmodule

// ===== hw/rtl/clr_queue.sv =====
`timescale 1ns / 1ps

module clr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  clr_pkg::pix_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output clr_pkg::pix_t pop_data_o
);
  import clr_pkg::*;

  pix_t                 entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]   count_q, count_d;

  assign full_o     = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_BITS+1)'(push_i) - (QPTR_BITS+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/clr_back.sv =====
`timescale 1ns / 1ps

module clr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clr_pkg::orient_e   orient_i,
  input  logic               q_valid_i,
  input  clr_pkg::pix_t      q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output clr_pkg::out_item_t out_data_o
);
  import clr_pkg::*;

  localparam int unsigned PROD_BITS = COORD_BITS + $clog2(PANEL_WIDTH + 1);
  localparam logic [COORD_BITS:0]   PW_EXT  = (COORD_BITS+1)'(PANEL_WIDTH);
  localparam logic [COORD_BITS:0]   PH_EXT  = (COORD_BITS+1)'(PANEL_HEIGHT);
  localparam logic [COORD_BITS-1:0] PW_LAST = COORD_BITS'(PANEL_WIDTH - 1);
  localparam logic [COORD_BITS-1:0] PH_LAST = COORD_BITS'(PANEL_HEIGHT - 1);

  logic                  valid_q, valid_d;
  out_item_t             data_q, data_d;
  logic                  land;
  logic [COORD_BITS:0]   lw, lh;
  logic                  on_screen;
  logic [COORD_BITS-1:0] row, col;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS-1:0]  addr_full;

  // logical screen test
  assign land      = orient_i[1];
  assign lw        = land ? PH_EXT : PW_EXT;
  assign lh        = land ? PW_EXT : PH_EXT;
  assign on_screen = ({1'b0, q_data_i.x} < lw) && ({1'b0, q_data_i.y} < lh);

  // panel row and column per orientation
  always_comb begin
    case (orient_i)
      ORIENT_PORTRAIT: begin
        row = q_data_i.y;
        col = q_data_i.x;
      end
      ORIENT_INV_PORTRAIT: begin
        row = PH_LAST - q_data_i.y;
        col = PW_LAST - q_data_i.x;
      end
      ORIENT_LEFT_LAND: begin
        row = q_data_i.x;
        col = PW_LAST - q_data_i.y;
      end
      ORIENT_RIGHT_LAND: begin
        row = PH_LAST - q_data_i.x;
        col = q_data_i.y;
      end
      default: begin
        row = q_data_i.y;
        col = q_data_i.x;
      end
    endcase
  end

  assign prod      = PROD_BITS'(row) * PROD_BITS'(PANEL_WIDTH);
  assign addr_full = prod + PROD_BITS'(col);

  // output register takes a pixel when empty or draining
  assign pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (pop_o) begin
      valid_d              = 1'b1;
      data_d.fb_address    = on_screen ? ADDR_BITS'(addr_full) : '0;
      data_d.out_color     = q_data_i.color;
      data_d.write_enable  = on_screen;
      data_d.last_pixel    = q_data_i.last;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/clipped_line_rasterizer.sv =====
`timescale 1ns / 1ps

// Bresenham line rasterizer with screen clipping and panel orientation.
// Input channel (in_valid_i / in_stall_o / in_data_i): a beat of kind line
// loads both endpoints and the color and gives no result; a beat of kind
// tick gives the current pixel of the line and advances one step. A tick
// while no line is active gives nothing. A new line replaces the old one.
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat per
// active tick with the framebuffer word address, color, write flag (clear
// with address zero when the pixel is off screen) and a flag on the end pixel.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): orientation,
// always ready; the user must write it only while no pixel is in flight,
// which the block does not enforce. A tick's pixel is written into the queue,
// then into the output register, which it leaves while out_stall_i is low.
// Throughput: one tick per cycle while in_stall_o is low, as the walker steps
// combinationally and the address mapper uses one constant multiply.
// A four-entry pixel queue sits between walker and mapper; when the receiver
// stalls, the queue fills and in_stall_o rises once it is full.
// Reset clears the walker to idle, empties the queue and output register and
// sets portrait orientation.

module clipped_line_rasterizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  clr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output clr_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);
  import clr_pkg::*;

  orient_e orient_q;
  logic    q_full, q_valid, push, pop;
  pix_t    push_data, pop_data;

  // orientation register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= ORIENT_PORTRAIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      orient_q <= orient_e'(cfg_data_i);
    end
  end

  clr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  clr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  clr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .orient_i    (orient_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/clr_checker.sv =====
`timescale 1ns / 1ps

module clr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input clr_pkg::out_item_t out_data_o
);
  import clr_pkg::*;

  // off-screen pixels carry a zero address
  a_offscreen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable |-> out_data_o.fb_address == '0)
    else $error("off-screen pixel with nonzero address");

  // written pixels stay inside the panel memory
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable
      |-> out_data_o.fb_address < ADDR_BITS'(PANEL_PIXELS))
    else $error("framebuffer address beyond panel");

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import clr_pkg::*;

  localparam int LIMIT     = 400000;
  localparam int LONG_HOLD = 60;
  localparam int SETTLE    = 4;
  localparam int TAIL      = 10;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  // one stimulus row; typed rows carry their own expected pixel
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    logic      has_px;
    out_item_t px;
  } row_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  in_item_t   in_data_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [1:0] cfg_data_i  = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  out_item_t  out_data_o;
  logic       cfg_ready_o;

  clipped_line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // walker state mirror
  orient_e               orient = ORIENT_PORTRAIT;
  bit                    walking;
  logic [COORD_BITS-1:0] pos_x, pos_y, tgt_x, tgt_y, span_x, span_y;
  bit                    back_x, back_y;
  int                    err_acc;
  logic [COLOR_BITS-1:0] ink;

  out_item_t pixel_q[$];
  out_item_t want;
  int        cycles;
  int        mismatches;
  int        beats_taken;
  int        beats_counted;
  int        pixels_seen;
  bit        calm;
  bit        hold_req;

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // one walker step: line load or tick; returns 1 when a pixel comes out
  function automatic bit trace_step(input in_item_t it, output out_item_t px);
    int          e2, dx, dy;
    int unsigned lw, lh, ax, ay, addr;
    px = '0;
    if (it.kind == KIND_LINE) begin
      pos_x   = it.start_x;
      pos_y   = it.start_y;
      tgt_x   = it.end_x;
      tgt_y   = it.end_y;
      span_x  = (it.end_x > it.start_x) ? it.end_x - it.start_x : it.start_x - it.end_x;
      span_y  = (it.end_y > it.start_y) ? it.end_y - it.start_y : it.start_y - it.end_y;
      back_x  = !(it.start_x < it.end_x);
      back_y  = !(it.start_y < it.end_y);
      err_acc = int'(span_x) - int'(span_y);
      ink     = it.pixel_color;
      walking = 1'b1;
      return 1'b0;
    end
    if (!walking) return 1'b0;

    // clip against the logical screen, then map to the panel word
    lw = orient[1] ? PANEL_HEIGHT : PANEL_WIDTH;
    lh = orient[1] ? PANEL_WIDTH : PANEL_HEIGHT;
    ax = 32'(pos_x);
    ay = 32'(pos_y);
    addr = 0;
    if (ax < lw && ay < lh) begin
      px.write_enable = 1'b1;
      case (orient)
        ORIENT_PORTRAIT:     addr = ay * PANEL_WIDTH + ax;
        ORIENT_INV_PORTRAIT: addr = (PANEL_HEIGHT - 1 - ay) * PANEL_WIDTH
                                    + (PANEL_WIDTH - 1 - ax);
        ORIENT_LEFT_LAND:    addr = ax * PANEL_WIDTH + (PANEL_WIDTH - 1 - ay);
        default:             addr = (PANEL_HEIGHT - 1 - ax) * PANEL_WIDTH + ay;
      endcase
    end
    px.fb_address = ADDR_BITS'(addr);
    px.out_color  = ink;
    px.last_pixel = (pos_x == tgt_x) && (pos_y == tgt_y);

    // advance one bresenham step
    if (px.last_pixel) begin
      walking = 1'b0;
    end else begin
      dx = int'(span_x);
      dy = int'(span_y);
      e2 = 2 * err_acc;
      if (e2 > -dy) begin
        err_acc -= dy;
        pos_x = back_x ? pos_x - 1'b1 : pos_x + 1'b1;
      end
      if (e2 < dx) begin
        err_acc += dx;
        pos_y = back_y ? pos_y - 1'b1 : pos_y + 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic in_item_t noise_item();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic row_t line_row(input int sx, input int sy, input int ex, input int ey,
                                    input int col);
    row_t r;
    r = '0;
    r.item.kind        = KIND_LINE;
    r.item.start_x     = sx[COORD_BITS-1:0];
    r.item.start_y     = sy[COORD_BITS-1:0];
    r.item.end_x       = ex[COORD_BITS-1:0];
    r.item.end_y       = ey[COORD_BITS-1:0];
    r.item.pixel_color = col[COLOR_BITS-1:0];
    return r;
  endfunction

  // tick with random unused fields, optionally with a typed expectation
  function automatic row_t tick_row(input bit typed, input bit has_px, input out_item_t px);
    row_t r;
    r        = '0;
    r.item   = noise_item();
    r.item.kind = KIND_TICK;
    r.typed  = typed;
    r.has_px = has_px;
    r.px     = px;
    return r;
  endfunction

  // offer one beat, with an occasional gap ahead of it
  task automatic offer(input row_t r);
    bit        got;
    out_item_t px;
    int        gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r.item;
    do @(posedge clk_i); while (in_stall_o);
    got = trace_step(r.item, px);
    if (r.typed) begin
      got = r.has_px;
      px  = r.px;
    end
    if (got) pixel_q.push_back(px);
    if (r.item.kind == KIND_LINE || got) beats_counted++;
    beats_taken++;
  endtask

  task automatic drain_pixels(input int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_orientation(input orient_e o);
    drain_pixels(SETTLE);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= o;
    do @(posedge clk_i); while (!cfg_ready_o);
    orient = o;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int span_of(input logic [COORD_BITS-1:0] a, input logic [COORD_BITS-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // random lines: mostly short walked lines near the screen, some wide, some noise
  task automatic run_random(input int quota);
    int   start, pick, span, off, n, k;
    row_t r;
    start = beats_counted;
    while (beats_counted - start < quota) begin
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        r = '0;
        r.item = noise_item();
        offer(r);
      end else begin
        r = '0;
        r.item = noise_item();
        r.item.kind = KIND_LINE;
        if (pick < 8) begin
          r.item.start_x = COORD_BITS'($urandom_range(0, 340));
          r.item.start_y = COORD_BITS'($urandom_range(0, 340));
          span = ($urandom_range(0, 3) == 0) ? 40 : 12;
          off  = $urandom_range(0, 2 * span);
          r.item.end_x = clamp_coord(int'(r.item.start_x) + off - span);
          off  = $urandom_range(0, 2 * span);
          r.item.end_y = clamp_coord(int'(r.item.start_y) + off - span);
          if ($urandom_range(0, 15) == 0) begin
            r.item.end_x = r.item.start_x;
            r.item.end_y = r.item.start_y;
          end
          n = 1 + ((span_of(r.item.start_x, r.item.end_x) > span_of(r.item.start_y,
                    r.item.end_y)) ? span_of(r.item.start_x, r.item.end_x)
                                   : span_of(r.item.start_y, r.item.end_y));
        end else begin
          n = $urandom_range(1, 8);
        end
        // sometimes cut the line short, sometimes tick past its end
        k = $urandom_range(0, 9);
        if (k == 0) n = $urandom_range(1, n);
        else if (k == 1) n += $urandom_range(1, 2);
        offer(r);
        repeat (n) offer(tick_row(1'b0, 1'b0, '0));
      end
    end
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin : receiver
    int burst;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall_i <= 1'b1;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // pixel checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        note_mismatch("pixel beat with nothing pending");
      end else begin
        want = pixel_q.pop_front();
        if (out_data_o.fb_address !== want.fb_address)
          note_mismatch($sformatf("fb_address %0d, want %0d",
                                  out_data_o.fb_address, want.fb_address));
        if (out_data_o.out_color !== want.out_color)
          note_mismatch($sformatf("out_color %h, want %h",
                                  out_data_o.out_color, want.out_color));
        if (out_data_o.write_enable !== want.write_enable)
          note_mismatch($sformatf("write_enable %b, want %b",
                                  out_data_o.write_enable, want.write_enable));
        if (out_data_o.last_pixel !== want.last_pixel)
          note_mismatch($sformatf("last_pixel %b, want %b",
                                  out_data_o.last_pixel, want.last_pixel));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    row_t plan[$];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, portrait after reset
    plan.push_back(tick_row(1'b1, 1'b0, '0));                          // idle tick
    plan.push_back(line_row(0, 0, 0, 0, 'hFFFF));                      // single pixel
    plan.push_back(tick_row(1'b1, 1'b1, {17'd0, 16'hFFFF, 1'b1, 1'b1}));
    plan.push_back(tick_row(1'b1, 1'b0, '0));                          // back to idle
    plan.push_back(line_row(239, 319, 239, 319, 'h0000));              // far corner
    plan.push_back(tick_row(1'b1, 1'b1, {17'd76799, 16'h0000, 1'b1, 1'b1}));
    plan.push_back(line_row(240, 0, 240, 0, 'h1234));                  // just off screen
    plan.push_back(tick_row(1'b1, 1'b1, {17'd0, 16'h1234, 1'b0, 1'b1}));
    plan.push_back(line_row(COORD_MAX, COORD_MAX, 0, 0, 'hA5A5));      // top coordinates
    plan.push_back(tick_row(1'b1, 1'b1, {17'd0, 16'hA5A5, 1'b0, 1'b0}));
    plan.push_back(tick_row(1'b0, 1'b0, '0));
    plan.push_back(line_row(0, 0, 3, 1, 'h5A5A));                      // replaces the line
    repeat (4) plan.push_back(tick_row(1'b0, 1'b0, '0));
    plan.push_back(line_row(10, 7, 8, 12, 'h001F));                    // steep, x falling
    repeat (6) plan.push_back(tick_row(1'b0, 1'b0, '0));
    plan.push_back(line_row(0, 0, COORD_MAX, COORD_MAX, 'hFFFF));
    plan.push_back(tick_row(1'b0, 1'b0, '0));
    foreach (plan[i]) offer(plan[i]);

    // fill the block while the receiver holds off
    set_orientation(ORIENT_LEFT_LAND);
    offer(line_row(3, 5, 200, 90, 'h7E0F));
    hold_req = 1'b1;
    repeat (40) offer(tick_row(1'b0, 1'b0, '0));
    run_random(200);

    set_orientation(ORIENT_INV_PORTRAIT);
    run_random(100);
    drain_pixels(0);
    run_random(100);

    set_orientation(ORIENT_RIGHT_LAND);
    run_random(200);
    set_orientation(ORIENT_PORTRAIT);
    run_random(200);
    set_orientation(ORIENT_RIGHT_LAND);
    run_random(100);
    calm = 1'b1;
    run_random(100);

    drain_pixels(TAIL);
    $display("tb: %0d beats taken, %0d pixels checked, %0d mismatches",
             beats_taken, pixels_seen, mismatches);
    $display("tb: all four orientations, clipped, degenerate, replaced lines and idle ticks");
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== clipped_line_rasterizer.f =====
hw/rtl/clr_pkg.sv
hw/rtl/clr_front.sv
hw/rtl/clr_queue.sv
hw/rtl/clr_back.sv
hw/rtl/clipped_line_rasterizer.sv
hw/rtl/clr_checker.sv
tb/tb.sv
